// ----- rtl/sorted_unique_key_table_core_macros.svh -----
// Assertion helpers for the key table core
`ifndef SORTED_UNIQUE_KEY_TABLE_CORE_MACROS_SVH
`define SORTED_UNIQUE_KEY_TABLE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SUKT_ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("key table: same-cycle check failed");
`define SUKT_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("key table: next-cycle check failed");
`else
`define SUKT_ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define SUKT_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif

`endif

// ----- rtl/sukt_pkg.sv -----
package sukt_pkg;

  localparam int KEY_W  = 152;
  localparam int NAME_W = 80;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [NAME_W-1:0] name_t;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_QUERY  = 3'd2;
  localparam logic [2:0] CMD_RENAME = 3'd3;
  localparam logic [2:0] CMD_REKEY  = 3'd4;
  localparam logic [2:0] CMD_COUNT  = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic ins;
    logic del;
    logic ren;
    logic use_b;
  } cell_op_t;

endpackage

// ----- rtl/sukt_cell.sv -----
module sukt_cell (
  input  logic              clk,
  input  logic              occ,
  input  sukt_pkg::cell_op_t op,
  input  sukt_pkg::key_t    probe_a,
  input  sukt_pkg::key_t    probe_b,
  input  sukt_pkg::key_t    ins_key,
  input  sukt_pkg::name_t   ins_name,
  input  logic              left_g,
  input  sukt_pkg::key_t    left_key,
  input  sukt_pkg::name_t   left_name,
  input  sukt_pkg::key_t    right_key,
  input  sukt_pkg::name_t   right_name,
  output logic              g_out,
  output sukt_pkg::key_t    key,
  output sukt_pkg::name_t   name,
  output logic              eq_a,
  output logic              eq_b
);
  import sukt_pkg::*;

  key_t  key_r;
  name_t name_r;
  logic  eq_a_r;
  logic  gt_a_r;
  logic  eq_b_r;
  logic  gt_b_r;

  assign g_out = occ & (op.use_b ? gt_b_r : gt_a_r);
  assign key   = key_r;
  assign name  = name_r;
  assign eq_a  = eq_a_r;
  assign eq_b  = eq_b_r;

  always_ff @(posedge clk) begin
    eq_a_r <= (probe_a == key_r);
    gt_a_r <= (probe_a > key_r);
    eq_b_r <= (probe_b == key_r);
    gt_b_r <= (probe_b > key_r);
  end

  // shift left on delete, shift right or load on insert, overwrite name on rename
  always_ff @(posedge clk) begin
    if (op.del && occ && !gt_a_r) begin
      key_r  <= right_key;
      name_r <= right_name;
    end else if (op.ins && !g_out) begin
      if (left_g) begin
        key_r  <= ins_key;
        name_r <= ins_name;
      end else begin
        key_r  <= left_key;
        name_r <= left_name;
      end
    end else if (op.ren && occ && eq_a_r) begin
      name_r <= ins_name;
    end
  end

endmodule

// ----- rtl/sorted_unique_key_table_core.sv -----
// An accepted command word passes through the compare, execute and done states before its
// result word is offered; a rekey that moves a record also passes the gap and insert states.
// A new command word is taken only in the idle state, once the previous result is registered;
// the decision step waits on the registered compare flags of the cell chain.
// Reset: synchronous active-low rst_n empties the table and clears the output valid flag; record
// cells hold no reset.
module sorted_unique_key_table_core #(
  parameter int CAPACITY = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[2:0], key_hi[66:3], key_mid[130:67], key_lo[154:131], name_hi[218:155],
  // name_lo[234:219], new_key_hi[298:235], new_key_mid[362:299], new_key_lo[386:363], zero pad
  input  logic [391:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], entry_count[7:2]
  output logic [7:0]   out_tdata
);
  import sukt_pkg::*;

  `include "sorted_unique_key_table_core_macros.svh"

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CMP  = 6'b000010,
    S_EXEC = 6'b000100,
    S_GAP  = 6'b001000,
    S_INS  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t       state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [2:0]   cmd_r;
  key_t         k_r, nk_r;
  name_t        name_r, saved_name_r, saved_name_nxt;
  logic [1:0]   st_r, st_nxt;
  logic         out_valid_r;
  logic [1:0]   out_status_r;
  logic [5:0]   out_count_r;

  cell_op_t     op;
  key_t         ins_key;
  name_t        ins_name;
  logic [CAPACITY-1:0] occ, eq_a, eq_b;
  logic [CAPACITY:0]   g_chain;
  key_t         key_w  [0:CAPACITY];
  name_t        name_w [0:CAPACITY];
  logic         found_a, found_b, same_key, full;
  name_t        hit_name;

  assign in_tready  = (state_r == S_IDLE) && rst_n;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_status_r};

  assign g_chain[0]       = 1'b1;
  assign key_w[CAPACITY]  = '0;
  assign name_w[CAPACITY] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign occ[gi] = (CW'(gi) < count_r);
      sukt_cell u_cell (
        .clk       (clk),
        .occ       (occ[gi]),
        .op        (op),
        .probe_a   (k_r),
        .probe_b   (nk_r),
        .ins_key   (ins_key),
        .ins_name  (ins_name),
        .left_g    (g_chain[gi]),
        .left_key  (key_w[(gi == 0) ? 0 : gi - 1]),
        .left_name (name_w[(gi == 0) ? 0 : gi - 1]),
        .right_key (key_w[gi + 1]),
        .right_name(name_w[gi + 1]),
        .g_out     (g_chain[gi + 1]),
        .key       (key_w[gi]),
        .name      (name_w[gi]),
        .eq_a      (eq_a[gi]),
        .eq_b      (eq_b[gi])
      );
    end
  endgenerate

  assign found_a  = |(eq_a & occ);
  assign found_b  = |(eq_b & occ);
  assign same_key = |(eq_a & eq_b & occ);
  assign full     = (count_r >= CW'(CAPACITY));
  assign ins_key  = op.use_b ? nk_r : k_r;
  assign ins_name = op.use_b ? saved_name_r : name_r;

  always_comb begin
    hit_name = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_name = hit_name | (name_w[i] & {NAME_W{eq_a[i] & occ[i]}});
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    st_nxt         = st_r;
    saved_name_nxt = saved_name_r;
    op             = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        st_nxt    = ST_OK;
        case (cmd_r)
          CMD_INSERT: begin
            if (found_a) begin
              st_nxt = ST_DUPLICATE;
            end else if (full) begin
              st_nxt = ST_FULL;
            end else begin
              op.ins    = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          CMD_DELETE: begin
            if (found_a) begin
              op.del    = 1'b1;
              count_nxt = count_r - 1'b1;
            end else begin
              st_nxt = ST_NOT_FOUND;
            end
          end
          CMD_QUERY: begin
            if (!found_a) begin
              st_nxt = ST_NOT_FOUND;
            end
          end
          CMD_RENAME: begin
            if (found_a) begin
              op.ren = 1'b1;
            end else begin
              st_nxt = ST_NOT_FOUND;
            end
          end
          CMD_REKEY: begin
            if (!found_a) begin
              st_nxt = ST_NOT_FOUND;
            end else if (found_b && !same_key) begin
              st_nxt = ST_DUPLICATE;
            end else if (!same_key) begin
              op.del         = 1'b1;
              count_nxt      = count_r - 1'b1;
              saved_name_nxt = hit_name;
              state_nxt      = S_GAP;
            end
          end
          default: begin
          end
        endcase
      end
      S_GAP: begin
        state_nxt = S_INS;
      end
      S_INS: begin
        op.ins    = 1'b1;
        op.use_b  = 1'b1;
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r         <= st_nxt;
    saved_name_r <= saved_name_nxt;
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tdata[2:0];
      k_r    <= {in_tdata[66:3], in_tdata[130:67], in_tdata[154:131]};
      name_r <= {in_tdata[218:155], in_tdata[234:219]};
      nk_r   <= {in_tdata[298:235], in_tdata[362:299], in_tdata[386:363]};
    end
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_status_r <= st_r;
      out_count_r  <= 6'(count_r);
    end
  end

  `SUKT_ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  `SUKT_ASSERT_IMPLIES(a_unique_hit, clk, rst_n, state_r == S_EXEC, $onehot0(eq_a & occ))
  `SUKT_ASSERT_NEXT(a_gap_to_ins, clk, rst_n, state_r == S_GAP, state_r == S_INS)
  `SUKT_ASSERT_NEXT(a_insert_grows, clk, rst_n, state_r == S_EXEC && cmd_r == CMD_INSERT && !found_a && !full, count_r == $past(count_r) + 1'b1)

endmodule

// ----- bench/sorted_unique_key_table_core_tb.sv -----
module sorted_unique_key_table_core_tb;
  import sukt_pkg::*;

  localparam int CAPACITY = 32;
  localparam int POOL_SIZE = 44;
  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic [1:0] st;
    logic [5:0] cnt;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [391:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;

  key_t  tbl_key [CAPACITY];
  name_t tbl_name [CAPACITY];
  int    tbl_used = 0;

  key_t   key_pool [POOL_SIZE];
  reply_t replies_due[$];
  int     mismatches = 0;
  int     quiet_cycles = 0;
  bit     calm = 1'b0;

  sorted_unique_key_table_core #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 7);
  end

  function automatic int locate_key(key_t k);
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_key[i] == k) return i;
    end
    return tbl_used;
  endfunction

  function automatic void remove_record(int at);
    for (int i = at; i + 1 < tbl_used; i++) begin
      tbl_key[i] = tbl_key[i + 1];
      tbl_name[i] = tbl_name[i + 1];
    end
    tbl_used--;
  endfunction

  function automatic void place_record(key_t k, name_t nm);
    int pos;
    pos = 0;
    while (pos < tbl_used && k > tbl_key[pos]) pos++;
    for (int i = tbl_used; i > pos; i--) begin
      tbl_key[i] = tbl_key[i - 1];
      tbl_name[i] = tbl_name[i - 1];
    end
    tbl_key[pos] = k;
    tbl_name[pos] = nm;
    tbl_used++;
  endfunction

  function automatic reply_t apply_command(logic [2:0] cmd, key_t k, name_t nm, key_t nk);
    reply_t r;
    int i;
    int j;
    name_t kept;
    r.st = ST_OK;
    i = locate_key(k);
    case (cmd)
      CMD_INSERT: begin
        if (i < tbl_used) r.st = ST_DUPLICATE;
        else if (tbl_used >= CAPACITY) r.st = ST_FULL;
        else place_record(k, nm);
      end
      CMD_DELETE: begin
        if (i < tbl_used) remove_record(i);
        else r.st = ST_NOT_FOUND;
      end
      CMD_QUERY: begin
        if (i >= tbl_used) r.st = ST_NOT_FOUND;
      end
      CMD_RENAME: begin
        if (i < tbl_used) tbl_name[i] = nm;
        else r.st = ST_NOT_FOUND;
      end
      CMD_REKEY: begin
        if (i >= tbl_used) begin
          r.st = ST_NOT_FOUND;
        end else begin
          j = locate_key(nk);
          if (j < tbl_used && j != i) begin
            r.st = ST_DUPLICATE;
          end else if (j != i) begin
            kept = tbl_name[i];
            remove_record(i);
            place_record(nk, kept);
          end
        end
      end
      default: ;
    endcase
    r.cnt = 6'(tbl_used);
    return r;
  endfunction

  function automatic key_t rand_key();
    logic [159:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return r[151:0];
  endfunction

  function automatic name_t rand_name();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return r[79:0];
  endfunction

  function automatic key_t text_key(int len);
    key_t k;
    k = '0;
    for (int i = 0; i < len; i++) k[151 - 8 * i -: 8] = 8'($urandom_range(97, 122));
    return k;
  endfunction

  function automatic key_t pick_key();
    if ($urandom_range(99) < 88) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return rand_key();
  endfunction

  task automatic build_key_pool();
    key_t k;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      case (i % 4)
        0: k = text_key($urandom_range(1, 19));
        1: k = rand_key();
        2: k = {key_pool[i - 1][151:24], 24'($urandom)};
        default: begin
          k = key_pool[i - 1];
          k[151 - 8 * $urandom_range(0, 17) -: 8] = 8'h00;
          k[7:0] = 8'($urandom_range(1, 255));
        end
      endcase
      key_pool[i] = k;
    end
  endtask

  task automatic send_word(logic [2:0] cmd, key_t k, name_t nm, key_t nk);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 15) gap = $urandom_range(4, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, nk[23:0], nk[87:24], nk[151:88], nm[15:0], nm[79:16],
                 k[23:0], k[87:24], k[151:88], cmd};
    do @(posedge clk); while (!in_tready);
    replies_due.push_back(apply_command(cmd, k, nm, nk));
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        want = replies_due.pop_front();
        if (out_tdata[1:0] !== want.st || out_tdata[7:2] !== want.cnt) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: got st=%0d cnt=%0d, want st=%0d cnt=%0d",
                     out_tdata[1:0], out_tdata[7:2], want.st, want.cnt);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic test_directed_cases();
    key_t zk;
    key_t ok;
    key_t tk;
    key_t gk;
    zk = '0;
    ok = '1;
    tk = text_key(19);
    gk = tk;
    gk[151 - 8 * 4 -: 8] = 8'h00;
    send_word(CMD_COUNT, zk, rand_name(), rand_key());
    send_word(CMD_QUERY, zk, rand_name(), rand_key());
    send_word(CMD_DELETE, ok, rand_name(), rand_key());
    send_word(CMD_RENAME, ok, rand_name(), rand_key());
    send_word(CMD_REKEY, zk, rand_name(), ok);
    send_word(CMD_INSERT, zk, '0, zk);
    send_word(CMD_INSERT, ok, '1, ok);
    send_word(CMD_INSERT, zk, rand_name(), rand_key());
    send_word(CMD_INSERT, tk, rand_name(), rand_key());
    send_word(CMD_QUERY, ok, rand_name(), rand_key());
    send_word(CMD_RENAME, ok, '0, rand_key());
    send_word(CMD_REKEY, tk, rand_name(), tk);
    send_word(CMD_REKEY, tk, rand_name(), ok);
    send_word(CMD_REKEY, tk, rand_name(), gk);
    send_word(CMD_INSERT, key_t'(1), rand_name(), rand_key());
    send_word(CMD_INSERT, {gk[151:24], 24'hFFFFFF}, rand_name(), rand_key());
    send_word(CMD_QUERY, gk, rand_name(), rand_key());
    send_word(CMD_QUERY, tk, rand_name(), rand_key());
    send_word(CMD_SPARE6, rand_key(), rand_name(), rand_key());
    send_word(CMD_SPARE7, rand_key(), rand_name(), rand_key());
    send_word(CMD_DELETE, zk, rand_name(), rand_key());
    send_word(CMD_DELETE, zk, rand_name(), rand_key());
    send_word(CMD_QUERY, ok, rand_name(), rand_key());
    send_word(CMD_COUNT, rand_key(), rand_name(), rand_key());
  endtask

  task automatic test_full_table();
    for (int i = 0; i < POOL_SIZE; i++) send_word(CMD_INSERT, key_pool[i], rand_name(), rand_key());
    send_word(CMD_INSERT, rand_key(), rand_name(), rand_key());
    send_word(CMD_INSERT, key_pool[2], rand_name(), rand_key());
    send_word(CMD_REKEY, key_pool[2], rand_name(), rand_key());
    send_word(CMD_REKEY, key_pool[3], rand_name(), key_pool[4]);
    send_word(CMD_RENAME, key_pool[5], rand_name(), rand_key());
    send_word(CMD_COUNT, rand_key(), rand_name(), rand_key());
    for (int i = 0; i < POOL_SIZE; i += 2) send_word(CMD_DELETE, key_pool[i], rand_name(), rand_key());
  endtask

  task automatic test_random_mix(int items, int ins_pct, int del_pct, bit no_gaps);
    int r;
    logic [2:0] cmd;
    key_t k;
    key_t nk;
    calm = no_gaps;
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(99);
      if (r < ins_pct) cmd = CMD_INSERT;
      else if (r < ins_pct + del_pct) cmd = CMD_DELETE;
      else if (r >= 97) cmd = ($urandom_range(1) != 0) ? CMD_SPARE7 : CMD_SPARE6;
      else begin
        case ($urandom_range(4))
          0: cmd = CMD_QUERY;
          1: cmd = CMD_RENAME;
          2, 3: cmd = CMD_REKEY;
          default: cmd = CMD_COUNT;
        endcase
      end
      k = pick_key();
      if (cmd == CMD_REKEY) begin
        r = $urandom_range(99);
        if (r < 10) nk = k;
        else if (r < 80) nk = key_pool[$urandom_range(POOL_SIZE - 1)];
        else nk = rand_key();
      end else begin
        nk = rand_key();
      end
      send_word(cmd, k, rand_name(), nk);
    end
    calm = 1'b0;
  endtask

  initial begin
    build_key_pool();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_full_table();
    test_random_mix(300, 60, 10, 1'b0);
    test_random_mix(300, 30, 25, 1'b1);
    test_random_mix(400, 30, 25, 1'b0);
    test_random_mix(250, 10, 60, 1'b0);
    drain_replies();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
